@@ design/lge_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lge_pkg: shared types and constants of the life grid engine
// no dependencies; used by lge_ctrl, lge_datapath and life_grid_engine

package lge_pkg;

  // configuration register width and reset count
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET_COUNT = 7'd64;

  // neighbor counts of the b3/s23 rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] SURVIVE_LIM = 4'd4;

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_COLS_IN_USE = 1'b0,
    REG_ROWS_IN_USE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_in;
  } item_t;

  typedef struct packed {
    logic cell_out;
    logic in_range;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // latch the incoming item
    logic acc_issue;   // read the addressed column word
    logic sweep_run;   // column sweep active
    logic sweep_zero;  // sweep writes zero columns (power-up clear)
    logic out_load;    // load the result register
    logic cell_write;  // write back the modified column word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_access;   // incoming item is an in-range read or write
    logic in_step;     // incoming item is a step
    logic held_write;  // held item is an in-range write
  } status_t;

endpackage

`default_nettype wire

@@ design/lge_chan_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lge_chan_if: valid/ready channel carrying one payload item
// payload type is a parameter; used with lge_pkg item and result types

interface lge_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/lge_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lge_ram: simple dual-port ram, one write and one registered read port
// no package dependencies

module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/lge_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lge_ctrl: sequencer of the life grid engine
// depends on lge_pkg (cmd_t, status_t)

module lge_ctrl #(
  parameter int MAX_COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire lge_pkg::status_t              status,
  output      lge_pkg::cmd_t                 cmd,
  output      logic [$clog2(MAX_COLS+2)-1:0] sweep_cnt
);

  localparam int CNT_W = $clog2(MAX_COLS + 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_COLS + 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_STEP   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] sweep_cnt_q;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign sweep_cnt = sweep_cnt_q;

  always_comb begin
    state_next = state;
    cnt_next   = sweep_cnt_q;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_run  = 1'b1;
        cmd.sweep_zero = 1'b1;
        cnt_next       = sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == CNT_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          cmd.load_item = 1'b1;
          if (status.in_access) begin
            cmd.acc_issue = 1'b1;
            state_next    = S_ACCESS;
          end else if (status.in_step) begin
            state_next = S_STEP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ACCESS: begin
        state_next = S_DONE;
      end
      S_STEP: begin
        cmd.sweep_run = 1'b1;
        cnt_next      = sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == CNT_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.cell_write = status.held_write;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      sweep_cnt_q <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      sweep_cnt_q <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/lge_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lge_datapath: grid memory, three-column window and b3/s23 lane logic
// depends on lge_pkg and lge_ram

module lge_datapath #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                          clk,
  input  wire lge_pkg::cmd_t                 cmd,
  input  wire logic [$clog2(MAX_COLS+2)-1:0] sweep_cnt,
  input  wire lge_pkg::item_t                item,
  input  wire logic [lge_pkg::CFG_W-1:0]     cols_in_use,
  input  wire logic [lge_pkg::CFG_W-1:0]     rows_in_use,
  output      lge_pkg::status_t              status,
  output      lge_pkg::result_t              result
);

  localparam int CA_W = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);

  lge_pkg::item_t item_r;
  logic           ok_r;

  logic [31:0] cols_wide, rows_wide, cnt_wide;
  logic [31:0] in_col_wide, in_row_wide, held_col_wide, held_row_wide, wa_wide;
  logic        in_ok;

  logic [MAX_ROWS-1:0] rdata, rmask, right_w, mid_r, left_r, life_w, cell_w;
  logic [MAX_ROWS+1:0] lp, mp, rp;
  logic                right_ok, mid_ok;

  logic            ram_we, ram_re;
  logic [CA_W-1:0] ram_waddr, ram_raddr;
  logic [MAX_ROWS-1:0] ram_wdata;
  logic [RW-1:0]   row_idx;

  assign cols_wide     = 32'(cols_in_use);
  assign rows_wide     = 32'(rows_in_use);
  assign cnt_wide      = 32'(sweep_cnt);
  assign in_col_wide   = 32'(item.col);
  assign in_row_wide   = 32'(item.row);
  assign held_col_wide = 32'(item_r.col);
  assign held_row_wide = 32'(item_r.row);
  assign wa_wide       = cnt_wide - 32'd2;
  assign row_idx       = held_row_wide[RW-1:0];

  // coordinate check on the incoming item
  assign in_ok = (in_col_wide < cols_wide) && (in_col_wide < 32'(MAX_COLS)) &&
                 (in_row_wide < rows_wide) && (in_row_wide < 32'(MAX_ROWS));

  assign status.in_access = in_ok &&
                            (item.opcode == lge_pkg::OP_WRITE ||
                             item.opcode == lge_pkg::OP_READ);
  assign status.in_step    = (item.opcode == lge_pkg::OP_STEP);
  assign status.held_write = ok_r && (item_r.opcode == lge_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= item;
      ok_r   <= in_ok;
    end
  end

  // rows in use
  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      rmask[r] = (32'(r) < rows_wide);
    end
  end

  // sweep: read column cnt, right is column cnt-1, mid cnt-2, left cnt-3
  assign right_ok = !cmd.sweep_zero && (cnt_wide >= 32'd1) &&
                    (cnt_wide <= 32'(MAX_COLS)) && ((cnt_wide - 32'd1) < cols_wide);
  assign mid_ok   = !cmd.sweep_zero && (wa_wide < cols_wide);
  assign right_w  = right_ok ? (rdata & rmask) : '0;

  always_ff @(posedge clk) begin
    if (cmd.sweep_run) begin
      left_r <= mid_r;
      mid_r  <= right_w;
    end
  end

  // one lane per row, dead beyond the edges
  assign lp = {1'b0, left_r, 1'b0};
  assign mp = {1'b0, mid_r, 1'b0};
  assign rp = {1'b0, right_w, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int r = 0; r < MAX_ROWS; r++) begin
      n = 4'(lp[r]) + 4'(lp[r+1]) + 4'(lp[r+2]) + 4'(mp[r]) + 4'(mp[r+2]) +
          4'(rp[r]) + 4'(rp[r+1]) + 4'(rp[r+2]);
      if (mp[r+1]) begin
        life_w[r] = (n >= lge_pkg::SURVIVE_MIN) && (n < lge_pkg::SURVIVE_LIM);
      end else begin
        life_w[r] = (n == lge_pkg::BIRTH_COUNT);
      end
    end
  end

  // single cell update of the held column word
  always_comb begin
    cell_w          = rdata;
    cell_w[row_idx] = item_r.cell_in;
  end

  always_comb begin
    ram_re    = cmd.acc_issue || (cmd.sweep_run && (cnt_wide < 32'(MAX_COLS)));
    ram_raddr = cmd.acc_issue ? in_col_wide[CA_W-1:0] : cnt_wide[CA_W-1:0];
    if (cmd.cell_write) begin
      ram_we    = 1'b1;
      ram_waddr = held_col_wide[CA_W-1:0];
      ram_wdata = cell_w;
    end else begin
      ram_we    = cmd.sweep_run && (cnt_wide >= 32'd2);
      ram_waddr = wa_wide[CA_W-1:0];
      ram_wdata = mid_ok ? (life_w & rmask) : '0;
    end
  end

  lge_ram #(
    .WIDTH (MAX_ROWS),
    .DEPTH (MAX_COLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.cell_out <= ok_r && (item_r.opcode == lge_pkg::OP_READ) && rdata[row_idx];
      result.in_range <= (item_r.opcode == lge_pkg::OP_STEP) ||
                         (ok_r && (item_r.opcode == lge_pkg::OP_WRITE ||
                                   item_r.opcode == lge_pkg::OP_READ));
    end
  end

endmodule

`default_nettype wire

@@ design/life_grid_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// life_grid_engine: top level, configuration registers and channel glue
// depends on lge_pkg, lge_chan_if, lge_ctrl, lge_datapath (with lge_ram)
//
// usage
//   item channel: opcode write cell, read cell or advance one generation
//     (b3/s23, cells beyond the area in use count as dead); col/row address
//     a cell, cell_in is the value to write
//   result channel: one item per input item, cell_out holds the cell read,
//     in_range is set for an accepted coordinate or a finished step
//   configuration: cfg_wen with cfg_index/cfg_data sets cols_in_use or
//     rows_in_use; write only while the block is idle
// timing
//   in-range read or write: accept, then the access state reads the column
//     word, then the done state loads the result; refused items skip access
//   step: one column word read and one written per cycle through the grid
//     ram while the step state sweeps, then the done state loads the result
//   reset: the grid is swept to all dead in the clear state, during which
//     no item is taken; configuration returns to 64 columns and 64 rows
//   stall: the result register holds its item until taken; a finished item
//     waits in the controller while the register is still full

module life_grid_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire lge_pkg::cfg_index_t       cfg_index,
  input  wire logic [lge_pkg::CFG_W-1:0] cfg_data,
  lge_chan_if.sink                       item,
  lge_chan_if.source                     result
);

  localparam int CNT_W = $clog2(MAX_COLS + 2);

  logic [lge_pkg::CFG_W-1:0] cols_in_use;
  logic [lge_pkg::CFG_W-1:0] rows_in_use;

  lge_pkg::cmd_t    cmd;
  lge_pkg::status_t status;
  logic [CNT_W-1:0] sweep_cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= lge_pkg::CFG_RESET_COUNT;
      rows_in_use <= lge_pkg::CFG_RESET_COUNT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lge_pkg::REG_COLS_IN_USE: cols_in_use <= cfg_data;
        lge_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: one item at a time, owns the result valid flag
  lge_ctrl #(
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd),
    .sweep_cnt (sweep_cnt)
  );

  // grid memory, generation logic and result register
  lge_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .sweep_cnt   (sweep_cnt),
    .item        (item.data),
    .cols_in_use (cols_in_use),
    .rows_in_use (rows_in_use),
    .status      (status),
    .result      (result.data)
  );

endmodule

`default_nettype wire
